// File: rtl/ssc_pkg.sv
// Shared types and constants for the sphere-sphere contact pipeline.
// Used by the contact top level and its square-root and divider cells; depends on nothing else.
`default_nettype none
package ssc_pkg;

    // Number of root bits resolved by the square-root chain (one per cell).
    localparam int unsigned SQRT_STEPS = 31;
    // Number of quotient bits resolved by the normal divider chain.
    localparam int unsigned DIV_STEPS  = 17;
    // Working widths of the square-root and divider partial remainders.
    localparam int unsigned SQRT_W     = 64;
    localparam int unsigned DREM_W     = 48;

    // 1.0 with 16 fraction bits (signed Q1.16) at the normal's width.
    localparam logic [17:0] ONE_Q16 = 18'd65536;

    // Saturation limits of a contact coordinate after the final shift.
    localparam logic signed [34:0] CONTACT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] CONTACT_MIN = -35'sd2147483648;

    // Per-word context that travels alongside the arithmetic down the pipe.
    typedef struct packed {
        logic             same;   // centres coincide
        logic             far;    // some axis is further apart than the radius sum
        logic             hit;    // spheres touch or overlap
        logic [2:0]       neg;    // sign of B - A per axis
        logic [2:0][30:0] mag;    // |B - A| per axis (valid when not far)
        logic [30:0]      rab;    // radius sum
        logic [2:0][32:0] asum;   // A + B per axis, signed
        logic [30:0]      rdiff;  // radius A - radius B, signed
        logic [30:0]      cdist;  // floor of the centre distance
    } ctx_t;

    typedef logic [2:0][DREM_W-1:0] div_rem_t;
    typedef logic [2:0][16:0]       quot_t;

endpackage
`default_nettype wire

// File: rtl/sphere_sphere_contact.sv
// Sphere-sphere contact pipeline; its length is set mostly by the 31-cell square-root
// chain and the 17-cell divider chain. Throughput one word per cycle unless m_ready
// stalls the output; every stage holds its own valid, so bubbles close up and a new
// word is taken while a finished one waits in the output register.
// Reset (synchronous, active low) clears all valid bits; no word is lost or invented.
// Depends on ssc_pkg, ssc_sqrt_cell and ssc_div_cell.
`default_nettype none
module sphere_sphere_contact (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_center_a_x,
    input  wire logic signed [31:0] s_center_a_y,
    input  wire logic signed [31:0] s_center_a_z,
    input  wire logic [29:0]        s_radius_a,
    input  wire logic signed [31:0] s_center_b_x,
    input  wire logic signed [31:0] s_center_b_y,
    input  wire logic signed [31:0] s_center_b_z,
    input  wire logic [29:0]        s_radius_b,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic signed [17:0]      m_normal_x,
    output logic signed [17:0]      m_normal_y,
    output logic signed [17:0]      m_normal_z,
    output logic [30:0]             m_penetration,
    output logic signed [31:0]      m_contact_x,
    output logic signed [31:0]      m_contact_y,
    output logic signed [31:0]      m_contact_z
);

    localparam int unsigned SQN = ssc_pkg::SQRT_STEPS;
    localparam int unsigned DVN = ssc_pkg::DIV_STEPS;

    // ---------------------------------------------------------------
    // Stage 1: differences, magnitudes, radius sum and difference.
    // ---------------------------------------------------------------
    logic                s1_valid_reg;
    logic                s1_ready;
    ssc_pkg::ctx_t       s1_ctx_reg, s1_ctx_next;
    logic signed [31:0]  ca [3];
    logic signed [31:0]  cb [3];
    logic signed [32:0]  dd [3];
    logic [32:0]         absd [3];

    always_comb begin
        ca[0] = s_center_a_x; ca[1] = s_center_a_y; ca[2] = s_center_a_z;
        cb[0] = s_center_b_x; cb[1] = s_center_b_y; cb[2] = s_center_b_z;
        s1_ctx_next       = '0;
        s1_ctx_next.rab   = {1'b0, s_radius_a} + {1'b0, s_radius_b};
        s1_ctx_next.rdiff = {1'b0, s_radius_a} - {1'b0, s_radius_b};
        s1_ctx_next.same  = 1'b1;
        for (int i = 0; i < 3; i++) begin
            dd[i]   = {cb[i][31], cb[i]} - {ca[i][31], ca[i]};
            absd[i] = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
            s1_ctx_next.neg[i]  = dd[i][32];
            s1_ctx_next.mag[i]  = absd[i][30:0];
            s1_ctx_next.asum[i] = {ca[i][31], ca[i]} + {cb[i][31], cb[i]};
            if (dd[i] != '0) begin
                s1_ctx_next.same = 1'b0;
            end
            if (absd[i] > {2'b00, s1_ctx_next.rab}) begin
                s1_ctx_next.far = 1'b1;
            end
        end
    end

    assign s_ready = ~s1_valid_reg | s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_ctx_reg <= s1_ctx_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: squares of the axis magnitudes and of the radius sum.
    // ---------------------------------------------------------------
    logic                s2_valid_reg;
    logic                s2_ready;
    ssc_pkg::ctx_t       s2_ctx_reg;
    logic [61:0]         s2_sq_reg [3];
    logic [61:0]         s2_rab2_reg;

    assign s1_ready = ~s2_valid_reg | s2_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s1_valid_reg) begin
            s2_ctx_reg  <= s1_ctx_reg;
            s2_rab2_reg <= 62'(s1_ctx_reg.rab) * 62'(s1_ctx_reg.rab);
            for (int i = 0; i < 3; i++) begin
                s2_sq_reg[i] <= 62'(s1_ctx_reg.mag[i]) * 62'(s1_ctx_reg.mag[i]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: squared distance, hit decision, square-root operand.
    // ---------------------------------------------------------------
    logic                          s3_valid_reg;
    logic                          s3_ready;
    ssc_pkg::ctx_t                 s3_ctx_reg, s3_ctx_next;
    logic [ssc_pkg::SQRT_W-1:0]    s3_x_reg, s3_x_next;
    logic [63:0]                   d2;

    always_comb begin
        d2 = 64'(s2_sq_reg[0]) + 64'(s2_sq_reg[1]) + 64'(s2_sq_reg[2]);
        s3_ctx_next     = s2_ctx_reg;
        s3_ctx_next.hit = s2_ctx_reg.same |
                          (~s2_ctx_reg.far & (d2 <= 64'(s2_rab2_reg)));
        s3_x_next = (s3_ctx_next.hit && !s2_ctx_reg.same) ? d2 : '0;
    end

    assign s2_ready = ~s3_valid_reg | s3_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s2_valid_reg) begin
            s3_ctx_reg <= s3_ctx_next;
            s3_x_reg   <= s3_x_next;
        end
    end

    // ---------------------------------------------------------------
    // Square-root chain: one root bit per cell.
    // ---------------------------------------------------------------
    logic                          sq_valid [SQN+1];
    logic                          sq_ready [SQN+1];
    ssc_pkg::ctx_t                 sq_ctx   [SQN+1];
    logic [ssc_pkg::SQRT_W-1:0]    sq_rem   [SQN+1];
    logic [ssc_pkg::SQRT_W-1:0]    sq_root  [SQN+1];

    assign sq_valid[0] = s3_valid_reg;
    assign s3_ready    = sq_ready[0];
    assign sq_ctx[0]   = s3_ctx_reg;
    assign sq_rem[0]   = s3_x_reg;
    assign sq_root[0]  = '0;

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        ssc_sqrt_cell #(
            .BIT_IDX (SQN - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_valid[k]),
            .in_ready  (sq_ready[k]),
            .in_ctx    (sq_ctx[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .out_valid (sq_valid[k+1]),
            .out_ready (sq_ready[k+1]),
            .out_ctx   (sq_ctx[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Divider set-up: numerator is |d| in Q31.16 plus half the distance.
    // ---------------------------------------------------------------
    logic                 dv_valid [DVN+1];
    logic                 dv_ready [DVN+1];
    ssc_pkg::ctx_t        dv_ctx   [DVN+1];
    ssc_pkg::div_rem_t    dv_rem   [DVN+1];
    ssc_pkg::quot_t       dv_quot  [DVN+1];
    ssc_pkg::ctx_t        dv0_ctx;
    ssc_pkg::div_rem_t    dv0_rem;

    always_comb begin
        dv0_ctx       = sq_ctx[SQN];
        dv0_ctx.cdist = sq_root[SQN][30:0];
        for (int i = 0; i < 3; i++) begin
            dv0_rem[i] = (ssc_pkg::DREM_W'(sq_ctx[SQN].mag[i]) << 16) +
                         ssc_pkg::DREM_W'(sq_root[SQN][30:1]);
        end
    end

    assign dv_ctx[0]     = dv0_ctx;
    assign dv_rem[0]     = dv0_rem;
    assign dv_valid[0]   = sq_valid[SQN];
    assign sq_ready[SQN] = dv_ready[0];
    assign dv_quot[0]    = '0;

    for (genvar k = 0; k < DVN; k++) begin : g_div
        ssc_div_cell #(
            .QBIT (DVN - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[k]),
            .in_ready  (dv_ready[k]),
            .in_ctx    (dv_ctx[k]),
            .in_rem    (dv_rem[k]),
            .in_quot   (dv_quot[k]),
            .out_valid (dv_valid[k+1]),
            .out_ready (dv_ready[k+1]),
            .out_ctx   (dv_ctx[k+1]),
            .out_rem   (dv_rem[k+1]),
            .out_quot  (dv_quot[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Normal stage: signed normal and its product with the radius difference.
    // ---------------------------------------------------------------
    logic                  nm_valid_reg;
    logic                  nm_ready;
    ssc_pkg::ctx_t         nm_ctx_reg;
    logic signed [17:0]    nm_n_reg    [3];
    logic signed [48:0]    nm_prod_reg [3];
    logic signed [17:0]    n_next      [3];
    logic [17:0]           qc          [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qc[i] = (18'(dv_quot[DVN][i]) > ssc_pkg::ONE_Q16) ?
                    ssc_pkg::ONE_Q16 : 18'(dv_quot[DVN][i]);
            n_next[i] = dv_ctx[DVN].neg[i] ? -$signed(qc[i]) : $signed(qc[i]);
        end
    end

    assign dv_ready[DVN] = ~nm_valid_reg | nm_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nm_valid_reg <= 1'b0;
        end else if (dv_ready[DVN]) begin
            nm_valid_reg <= dv_valid[DVN];
        end
    end

    always_ff @(posedge aclk) begin
        if (dv_ready[DVN] && dv_valid[DVN]) begin
            nm_ctx_reg <= dv_ctx[DVN];
            for (int i = 0; i < 3; i++) begin
                nm_n_reg[i]    <= n_next[i];
                nm_prod_reg[i] <= n_next[i] * $signed(dv_ctx[DVN].rdiff);
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: contact point rounding, saturation and result select.
    // ---------------------------------------------------------------
    logic                  m_valid_reg;
    logic                  m_hit_reg, m_hit_next;
    logic signed [17:0]    m_normal_reg [3];
    logic signed [17:0]    m_normal_next [3];
    logic [30:0]           m_pen_reg, m_pen_next;
    logic signed [31:0]    m_contact_reg [3];
    logic signed [31:0]    m_contact_next [3];
    logic signed [51:0]    acc [3];
    logic signed [34:0]    cq  [3];
    logic signed [31:0]    csat [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = $signed({{3{nm_ctx_reg.asum[i][32]}}, nm_ctx_reg.asum[i], 16'b0}) +
                     $signed({{3{nm_prod_reg[i][48]}}, nm_prod_reg[i]}) +
                     52'sd65536;
            cq[i]  = acc[i][51:17];
            if (cq[i] > ssc_pkg::CONTACT_MAX) begin
                csat[i] = 32'(ssc_pkg::CONTACT_MAX);
            end else if (cq[i] < ssc_pkg::CONTACT_MIN) begin
                csat[i] = 32'(ssc_pkg::CONTACT_MIN);
            end else begin
                csat[i] = cq[i][31:0];
            end
        end

        m_hit_next = nm_ctx_reg.hit;
        m_pen_next = '0;
        for (int i = 0; i < 3; i++) begin
            m_normal_next[i]  = '0;
            m_contact_next[i] = '0;
        end
        priority if (nm_ctx_reg.same) begin
            // Coincident centres: fixed normal along x, contact at centre A.
            m_normal_next[0] = $signed(ssc_pkg::ONE_Q16);
            m_pen_next       = nm_ctx_reg.rab;
            for (int i = 0; i < 3; i++) begin
                m_contact_next[i] = $signed(nm_ctx_reg.asum[i][32:1]);
            end
        end else if (nm_ctx_reg.hit) begin
            m_pen_next = nm_ctx_reg.rab - nm_ctx_reg.cdist;
            for (int i = 0; i < 3; i++) begin
                m_normal_next[i]  = nm_n_reg[i];
                m_contact_next[i] = csat[i];
            end
        end else begin
            m_hit_next = 1'b0;
        end
    end

    assign nm_ready = ~m_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (nm_ready) begin
            m_valid_reg <= nm_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (nm_ready && nm_valid_reg) begin
            m_hit_reg <= m_hit_next;
            m_pen_reg <= m_pen_next;
            for (int i = 0; i < 3; i++) begin
                m_normal_reg[i]  <= m_normal_next[i];
                m_contact_reg[i] <= m_contact_next[i];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_normal_x    = m_normal_reg[0];
    assign m_normal_y    = m_normal_reg[1];
    assign m_normal_z    = m_normal_reg[2];
    assign m_penetration = m_pen_reg;
    assign m_contact_x   = m_contact_reg[0];
    assign m_contact_y   = m_contact_reg[1];
    assign m_contact_z   = m_contact_reg[2];

endmodule
`default_nettype wire

// File: rtl/ssc_sqrt_cell.sv
// One cell of the square-root chain: resolves a single root bit per word.
// Depends on ssc_pkg for the context type and working width.
`default_nettype none
module ssc_sqrt_cell #(
    parameter int unsigned BIT_IDX = 30
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire ssc_pkg::ctx_t               in_ctx,
    input  wire logic [ssc_pkg::SQRT_W-1:0]  in_rem,
    input  wire logic [ssc_pkg::SQRT_W-1:0]  in_root,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output ssc_pkg::ctx_t                    out_ctx,
    output logic [ssc_pkg::SQRT_W-1:0]       out_rem,
    output logic [ssc_pkg::SQRT_W-1:0]       out_root
);

    localparam logic [ssc_pkg::SQRT_W-1:0] BIT_VAL =
        ssc_pkg::SQRT_W'(1) << (2 * BIT_IDX);

    logic                        valid_reg;
    ssc_pkg::ctx_t               ctx_reg;
    logic [ssc_pkg::SQRT_W-1:0]  rem_reg, rem_next;
    logic [ssc_pkg::SQRT_W-1:0]  root_reg, root_next;
    logic [ssc_pkg::SQRT_W-1:0]  trial;

    // Trial subtraction of root plus the current bit.
    always_comb begin
        trial = in_root + BIT_VAL;
        if (in_rem >= trial) begin
            rem_next  = in_rem - trial;
            root_next = (in_root >> 1) + BIT_VAL;
        end else begin
            rem_next  = in_rem;
            root_next = in_root >> 1;
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    // Stage register with its own valid so that bubbles close up.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctx_reg  <= in_ctx;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule
`default_nettype wire

// File: rtl/ssc_div_cell.sv
// One cell of the normal divider chain: one quotient bit for all three axes.
// Depends on ssc_pkg for the context, remainder and quotient types.
`default_nettype none
module ssc_div_cell #(
    parameter int unsigned QBIT = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ssc_pkg::ctx_t     in_ctx,
    input  wire ssc_pkg::div_rem_t in_rem,
    input  wire ssc_pkg::quot_t    in_quot,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ssc_pkg::ctx_t          out_ctx,
    output ssc_pkg::div_rem_t      out_rem,
    output ssc_pkg::quot_t         out_quot
);

    logic                            valid_reg;
    ssc_pkg::ctx_t                   ctx_reg;
    ssc_pkg::div_rem_t               rem_reg, rem_next;
    ssc_pkg::quot_t                  quot_reg, quot_next;
    logic [ssc_pkg::DREM_W-1:0]      dsh;

    // Compare each remainder against the divisor shifted to this bit.
    always_comb begin
        dsh       = ssc_pkg::DREM_W'(in_ctx.cdist) << QBIT;
        rem_next  = in_rem;
        quot_next = in_quot;
        for (int i = 0; i < 3; i++) begin
            if (in_rem[i] >= dsh) begin
                rem_next[i]        = in_rem[i] - dsh;
                quot_next[i][QBIT] = 1'b1;
            end
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctx_reg  <= in_ctx;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_rem   = rem_reg;
    assign out_quot  = quot_reg;

endmodule
`default_nettype wire

// File: rtl/ssc_checker.sv
// Port-level checker for the sphere-sphere contact block, bound to its top level.
// Depends only on the ports of sphere_sphere_contact.
`default_nettype none
module ssc_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic signed [31:0] s_center_a_x,
    input wire logic signed [31:0] s_center_a_y,
    input wire logic signed [31:0] s_center_a_z,
    input wire logic [29:0]        s_radius_a,
    input wire logic signed [31:0] s_center_b_x,
    input wire logic signed [31:0] s_center_b_y,
    input wire logic signed [31:0] s_center_b_z,
    input wire logic [29:0]        s_radius_b,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_hit,
    input wire logic signed [17:0] m_normal_x,
    input wire logic signed [17:0] m_normal_y,
    input wire logic signed [17:0] m_normal_z,
    input wire logic [30:0]        m_penetration,
    input wire logic signed [31:0] m_contact_x,
    input wire logic signed [31:0] m_contact_y,
    input wire logic signed [31:0] m_contact_z
);

    // A stalled result word holds its hit flag, penetration, x contact and x normal.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_penetration)
                                && $stable(m_contact_x) && $stable(m_normal_x))
        else $error("result word changed while stalled");

    // A miss carries zeros in every other field.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_normal_x == 18'sd0 && m_normal_y == 18'sd0 &&
            m_normal_z == 18'sd0 && m_penetration == 31'd0 &&
            m_contact_x == 32'sd0 && m_contact_y == 32'sd0 && m_contact_z == 32'sd0)
        else $error("miss with non-zero fields");

    // Normal components never exceed one in magnitude.
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_x <= 18'sd65536 && m_normal_x >= -18'sd65536 &&
            m_normal_y <= 18'sd65536 && m_normal_y >= -18'sd65536 &&
            m_normal_z <= 18'sd65536 && m_normal_z >= -18'sd65536)
        else $error("normal component out of range");

    // Reset empties the pipe.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind sphere_sphere_contact ssc_checker u_ssc_checker (.*);
`default_nettype wire
